// ===== rtl/pcrp_pkg.sv =====
// Package for the point cloud record parser: payload structs, job struct,
// status and kind codes, parser phases and color expansion functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcrp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // One queue entry: everything one input item causes.
   typedef struct packed {
      logic        has_point;
      logic        has_status;
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
      logic [15:0] color;
      logic [1:0]  status;
   } job_type;

   typedef enum logic [6:0] {
      PH_VERSION  = 7'b0000001,
      PH_SECTIONS = 7'b0000010,
      PH_PAIRS    = 7'b0000100,
      PH_VALUES   = 7'b0001000,
      PH_PTS_CNT  = 7'b0010000,
      PH_POINTS   = 7'b0100000,
      PH_DONE     = 7'b1000000
   } phase_type;

   localparam logic       KIND_POINT  = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_VERSION = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED   = 2'd2;

   localparam logic [31:0] VERSION_1_0    = 32'h0001_0000;
   localparam logic [3:0]  VER_LAST_POS   = 4'd3;
   localparam logic [3:0]  COLOR_LO_POS   = 4'd13;

   // v*255/31 and v*255/63, truncated, as reciprocal multiplies (2^20 scale).
   localparam logic [28:0] R5_SCALE = 29'd8625630;   // 255 * 33826
   localparam logic [28:0] G6_SCALE = 29'd4244475;   // 255 * 16645

   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [28:0] p;
      p = 29'(v) * R5_SCALE;
      return p[27:20];
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [28:0] p;
      p = 29'(v) * G6_SCALE;
      return p[27:20];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pcrp_front.sv =====
// Front end: parses the byte stream (version, header skip, point count,
// point records) and pushes one job per item that causes results. Uses pcrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrp_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  pcrp_pkg::req_type  req_data,
   output logic               push_valid,
   output pcrp_pkg::job_type  push_job,
   input  wire                push_ready
);
   import pcrp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [30:0] sec_ff, sec_in;
   logic [31:0] vl_ff, vl_in;
   logic [30:0] pts_ff, pts_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] ver_ff, ver_in;
   logic [1:0]  err_ff, err_in;
   logic [7:0]  rec_ff [13];

   logic        accept;
   logic [7:0]  b;
   logic [31:0] v;
   logic [30:0] sec_dec;
   logic [31:0] vl_dec;
   logic [30:0] pts_dec;
   logic        point;
   logic        store;
   phase_type   sec_next_phase;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;
   assign v         = {acc_ff[24:0], b[6:0]};
   assign sec_dec   = sec_ff - 31'd1;
   assign vl_dec    = vl_ff - 32'd1;
   assign pts_dec   = pts_ff - 31'd1;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      sec_in   = sec_ff;
      vl_in    = vl_ff;
      pts_in   = pts_ff;
      pos_in   = pos_ff;
      ver_in   = ver_ff;
      err_in   = err_ff;
      point    = 1'b0;
      store    = 1'b0;
      sec_next_phase = (sec_dec == 31'd0) ? PH_PTS_CNT : PH_PAIRS;

      case (phase_ff)
         PH_VERSION: begin
            ver_in = {ver_ff[23:0], b};
            pos_in = pos_ff + 4'd1;
            if (pos_ff == VER_LAST_POS) begin
               pos_in = 4'd0;
               if (ver_in != VERSION_1_0) begin
                  err_in   = STATUS_BAD_VERSION;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SECTIONS;
               end
            end
         end
         PH_POINTS: begin
            if (pos_ff < COLOR_LO_POS) begin
               store  = 1'b1;
               pos_in = pos_ff + 4'd1;
            end else begin
               point  = 1'b1;
               pos_in = 4'd0;
               pts_in = pts_dec;
               if (pts_dec == 31'd0) phase_in = PH_DONE;
            end
         end
         PH_SECTIONS, PH_PAIRS, PH_VALUES, PH_PTS_CNT: begin
            acc_in = v;
            if (b[7]) begin
               acc_in = 32'd0;
               case (phase_ff)
                  PH_SECTIONS: begin
                     sec_in   = v[31] ? 31'd0 : v[30:0];
                     phase_in = (v[31] || v[30:0] == 31'd0) ? PH_PTS_CNT : PH_PAIRS;
                  end
                  PH_PAIRS: begin
                     if (v[31] || v[30:0] == 31'd0) begin
                        sec_in   = sec_dec;
                        phase_in = sec_next_phase;
                     end else begin
                        vl_in    = {v[30:0], 1'b0};
                        phase_in = PH_VALUES;
                     end
                  end
                  PH_VALUES: begin
                     vl_in = vl_dec;
                     if (vl_dec == 32'd0) begin
                        sec_in   = sec_dec;
                        phase_in = sec_next_phase;
                     end
                  end
                  default: begin
                     pts_in   = v[31] ? 31'd0 : v[30:0];
                     pos_in   = 4'd0;
                     phase_in = (v[31] || v[30:0] == 31'd0) ? PH_DONE : PH_POINTS;
                  end
               endcase
            end
         end
         default: ;
      endcase

      push_job.has_point  = point;
      push_job.has_status = req_data.end_of_file;
      push_job.x_bits     = {rec_ff[0], rec_ff[1], rec_ff[2], rec_ff[3]};
      push_job.y_bits     = {rec_ff[4], rec_ff[5], rec_ff[6], rec_ff[7]};
      push_job.z_bits     = {rec_ff[8], rec_ff[9], rec_ff[10], rec_ff[11]};
      push_job.color      = {rec_ff[12], b};
      if (err_in != STATUS_OK) push_job.status = err_in;
      else if (phase_in == PH_DONE) push_job.status = STATUS_OK;
      else push_job.status = STATUS_TRUNCATED;

      // end of file returns the parser to its reset state
      if (req_data.end_of_file) begin
         phase_in = PH_VERSION;
         acc_in   = 32'd0;
         sec_in   = 31'd0;
         vl_in    = 32'd0;
         pts_in   = 31'd0;
         pos_in   = 4'd0;
         ver_in   = 32'd0;
         err_in   = STATUS_OK;
      end
   end

   assign push_valid = accept && (point || req_data.end_of_file);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERSION;
         acc_ff   <= 32'd0;
         sec_ff   <= 31'd0;
         vl_ff    <= 32'd0;
         pts_ff   <= 31'd0;
         pos_ff   <= 4'd0;
         ver_ff   <= 32'd0;
         err_ff   <= STATUS_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         sec_ff   <= sec_in;
         vl_ff    <= vl_in;
         pts_ff   <= pts_in;
         pos_ff   <= pos_in;
         ver_ff   <= ver_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) rec_ff[pos_ff] <= b;
   end

endmodule

`default_nettype wire

// ===== rtl/pcrp_queue.sv =====
// Small register FIFO of jobs between the parser front end and the result
// back end. Uses pcrp_pkg. DEPTH must be 2 or more.
`timescale 1ns / 1ps
`default_nettype none

module pcrp_queue #(
   parameter int DEPTH = 2
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push_valid,
   input  pcrp_pkg::job_type  push_job,
   output logic               push_ready,
   output logic               head_valid,
   output pcrp_pkg::job_type  head_job,
   input  wire                pop
);
   import pcrp_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       slot_ff [DEPTH];
   logic [IW-1:0] wr_ff, wr_in;
   logic [IW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LAST_IDX) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// ===== rtl/pcrp_back.sv =====
// Back end: turns queued jobs into result items (point, then status) in an
// output register, expanding RGB565 color. Uses pcrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrp_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                head_valid,
   input  pcrp_pkg::job_type  head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output pcrp_pkg::rsp_type  rsp_data
);
   import pcrp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    pt_sent_ff, pt_sent_in;
   logic    load;
   logic    send_point;

   assign load       = !rsp_valid_ff || rsp_ready;
   assign send_point = head_job.has_point && !pt_sent_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pt_sent_in   = pt_sent_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (send_point) begin
               rsp_in.kind   = KIND_POINT;
               rsp_in.x_bits = head_job.x_bits;
               rsp_in.y_bits = head_job.y_bits;
               rsp_in.z_bits = head_job.z_bits;
               rsp_in.red    = expand5(head_job.color[15:11]);
               rsp_in.green  = expand6(head_job.color[10:5]);
               rsp_in.blue   = expand5(head_job.color[4:0]);
               rsp_in.status = STATUS_OK;
               rsp_in.last   = !head_job.has_status;
               pt_sent_in    = head_job.has_status;
               pop           = !head_job.has_status;
            end else begin
               rsp_in.kind   = KIND_STATUS;
               rsp_in.x_bits = 32'd0;
               rsp_in.y_bits = 32'd0;
               rsp_in.z_bits = 32'd0;
               rsp_in.red    = 8'd0;
               rsp_in.green  = 8'd0;
               rsp_in.blue   = 8'd0;
               rsp_in.status = head_job.status;
               rsp_in.last   = 1'b1;
               pt_sent_in    = 1'b0;
               pop           = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pt_sent_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pt_sent_ff   <= pt_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/point_cloud_record_parser_top.sv =====
// Top level of the point cloud record parser: front end, job queue, back end.
// Depends on pcrp_pkg, pcrp_front, pcrp_queue and pcrp_back.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one file byte per clock on the req_ channel, with
// end_of_file marking the last byte of a file. It checks the big-endian 1.0
// version word, skips the varint header, reads the point count and returns
// one point item on rsp_ per 14-byte record, plus one status item at end of
// file (ok, unsupported version or truncated); after end of file it is ready
// for the next file at once. Bytes are taken every cycle while the queue has
// room: the front end parses each byte combinationally and drops a job into
// a QUEUE_DEPTH-entry queue. The back end drains one result item per cycle
// through its output register while rsp_ready allows; a point and its status
// from one byte leave as two items. A result is held in a queue slot, then in
// the output register. req_ready drops only when the queue is full: when the
// rsp_ side stalls, or for one cycle when a byte that yields a point and a
// status is followed at once by another byte that yields an item.

module point_cloud_record_parser_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  pcrp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output pcrp_pkg::rsp_type  rsp_data
);
   import pcrp_pkg::*;

   // front end -> queue
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // queue -> back end
   logic    head_valid;
   job_type head_job;
   logic    pop;

   pcrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   pcrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   pcrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for point_cloud_record_parser_top: streams point cloud
// files byte by byte and checks every point and status item against a model.
// Depends on pcrp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
   import pcrp_pkg::*;

   // ---------------------------------------------------------------------
   // Scoreboard: tracks the parser state byte by byte, queues the items each
   // accepted byte should produce and checks the response stream in order.
   // ---------------------------------------------------------------------
   class record_scoreboard;
      rsp_type     awaited_items[$];
      int unsigned errors = 0;
      int unsigned bytes_taken = 0;
      int unsigned files_seen = 0;
      int unsigned points_seen = 0;
      int unsigned status_seen[3] = '{0, 0, 0};

      // shadow of the parser state
      phase_type   ph;
      logic [31:0] acc;
      logic [31:0] ver;
      logic [31:0] vals_left;
      logic [30:0] secs_left;
      logic [30:0] pts_left;
      logic [3:0]  pos;
      logic [7:0]  rec[13];
      logic [1:0]  err;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         ph        = PH_VERSION;
         acc       = '0;
         ver       = '0;
         vals_left = '0;
         secs_left = '0;
         pts_left  = '0;
         pos       = '0;
         err       = STATUS_OK;
      endfunction

      // counts with the sign bit set read as zero
      function logic [30:0] as_count(logic [31:0] v);
         return v[31] ? 31'd0 : v[30:0];
      endfunction

      function void close_section();
         secs_left = secs_left - 31'd1;
         ph = (secs_left == 0) ? PH_PTS_CNT : PH_PAIRS;
      endfunction

      function logic [7:0] widen(logic [5:0] v, int unsigned top);
         int unsigned wide;
         wide = v;
         wide = (wide * 255) / top;
         return wide[7:0];
      endfunction

      // Advances the shadow state by one byte; returns 1 with a point item
      // when the byte completes a record.
      function bit parse_byte(logic [7:0] b, output rsp_type pt);
         logic [31:0] v;
         logic [30:0] c;
         logic [15:0] color;
         pt = '0;
         parse_byte = 1'b0;
         case (ph)
            PH_VERSION: begin
               ver = {ver[23:0], b};
               pos = pos + 4'd1;
               if (pos >= 4) begin
                  pos = '0;
                  if (ver != VERSION_1_0) begin
                     err = STATUS_BAD_VERSION;
                     ph  = PH_DONE;
                  end else begin
                     ph = PH_SECTIONS;
                  end
               end
            end
            PH_POINTS: begin
               if (pos < 13) begin
                  rec[pos] = b;
                  pos = pos + 4'd1;
               end else begin
                  color     = {rec[12], b};
                  pt.kind   = KIND_POINT;
                  pt.x_bits = {rec[0], rec[1], rec[2], rec[3]};
                  pt.y_bits = {rec[4], rec[5], rec[6], rec[7]};
                  pt.z_bits = {rec[8], rec[9], rec[10], rec[11]};
                  pt.red    = widen({1'b0, color[15:11]}, 31);
                  pt.green  = widen(color[10:5], 63);
                  pt.blue   = widen({1'b0, color[4:0]}, 31);
                  pt.status = STATUS_OK;
                  pos       = '0;
                  pts_left  = pts_left - 31'd1;
                  if (pts_left == 0) ph = PH_DONE;
                  parse_byte = 1'b1;
               end
            end
            PH_DONE: ;
            default: begin
               // varint phases: MSB group first, top bit ends the varint
               acc = {acc[24:0], b[6:0]};
               if (b[7]) begin
                  v   = acc;
                  acc = '0;
                  case (ph)
                     PH_SECTIONS: begin
                        secs_left = as_count(v);
                        ph = (secs_left == 0) ? PH_PTS_CNT : PH_PAIRS;
                     end
                     PH_PAIRS: begin
                        c = as_count(v);
                        if (c == 0) begin
                           close_section();
                        end else begin
                           vals_left = {c, 1'b0};
                           ph = PH_VALUES;
                        end
                     end
                     PH_VALUES: begin
                        vals_left = vals_left - 32'd1;
                        if (vals_left == 0) close_section();
                     end
                     default: begin
                        pts_left = as_count(v);
                        pos = '0;
                        ph = (pts_left == 0) ? PH_DONE : PH_POINTS;
                     end
                  endcase
               end
            end
         endcase
      endfunction

      // Called for every accepted input item.
      function void take_file_byte(req_type it);
         rsp_type pt;
         rsp_type st;
         bit      got;
         bytes_taken++;
         got = parse_byte(it.data_byte, pt);
         if (got) points_seen++;
         if (it.end_of_file) begin
            if (got) awaited_items.push_back(pt);
            st      = '0;
            st.kind = KIND_STATUS;
            if (err != STATUS_OK)  st.status = err;
            else if (ph == PH_DONE) st.status = STATUS_OK;
            else                    st.status = STATUS_TRUNCATED;
            st.last = 1'b1;
            awaited_items.push_back(st);
            status_seen[st.status]++;
            files_seen++;
            clear_state();
         end else if (got) begin
            pt.last = 1'b1;
            awaited_items.push_back(pt);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("mismatch @%0t: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s = %0h, expected %0h", name, got, want));
      endtask

      // Called for every accepted result item.
      task check_output(rsp_type got);
         rsp_type want;
         if (awaited_items.size() == 0) begin
            report($sformatf("unexpected item %h", got));
         end else begin
            want = awaited_items.pop_front();
            compare_field("kind",   got.kind,   want.kind);
            compare_field("x_bits", got.x_bits, want.x_bits);
            compare_field("y_bits", got.y_bits, want.y_bits);
            compare_field("z_bits", got.z_bits, want.z_bits);
            compare_field("red",    got.red,    want.red);
            compare_field("green",  got.green,  want.green);
            compare_field("blue",   got.blue,   want.blue);
            compare_field("status", got.status, want.status);
            compare_field("last",   got.last,   want.last);
         end
      endtask
   endclass

   // ---------------------------------------------------------------------
   // Signals, clock and DUT
   // ---------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   record_scoreboard sb = new();
   logic [7:0]       file_bytes[$];   // file under construction
   bit               calm = 1'b0;     // set: neither side idles

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   point_cloud_record_parser_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Idle length: mostly none or short, now and then a long one.
   function int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Appends a varint of the given group count. Groups above bit 31 carry
   // random filler so the accumulator's overflow drop is exercised.
   function void push_varint(logic [31:0] v, int unsigned groups);
      logic [6:0] g;
      for (int i = groups - 1; i >= 0; i--) begin
         if (i >= 5)      g = 7'($urandom_range(0, 127));
         else if (i == 4) g = {3'($urandom_range(0, 7)), v[31:28]};
         else             g = 7'(v >> (7 * i));
         file_bytes.push_back({i == 0, g});
      end
   endfunction

   // Count: small most of the time, now and then negative (reads as zero).
   function logic [31:0] rand_count(int unsigned top);
      if ($urandom_range(0, 9) == 0) return 32'h8000_0000 | $urandom;
      return $urandom_range(0, top);
   endfunction

   // Group count wide enough for v, sometimes padded with extra groups.
   function int unsigned rand_groups(logic [31:0] v);
      int unsigned need;
      int unsigned n;
      need = 1;
      while (need < 5 && (v >> (7 * need)) != 0) need++;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 1;
      return (n > need) ? n : need;
   endfunction

   // Sends one item; valid stays up from one item to the next when no gap
   // is picked, so back-to-back items see one assignment per edge.
   task send_item(req_type it);
      int unsigned g;
      g = pick_gap();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      sb.take_file_byte(it);
   endtask

   // Streams file_bytes with end_of_file on the final byte.
   task send_file();
      req_type it;
      for (int i = 0; i < file_bytes.size(); i++) begin
         it.data_byte   = file_bytes[i];
         it.end_of_file = (i == file_bytes.size() - 1);
         send_item(it);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, check on every handshake.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_output(rsp_data);
         if (hold != 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            hold = pick_gap();
            rsp_ready <= (hold == 0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int unsigned kind;
      int unsigned n;
      int unsigned fill;
      int unsigned drain;
      logic [31:0] cnt;
      logic [31:0] pairs;
      logic [31:0] word;
      logic [30:0] nsec;
      logic [30:0] npts;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: end of file inside the version word (truncated).
      file_bytes = '{8'h00};
      send_file();
      // Directed: version 2.0, rejected on its last byte.
      file_bytes = '{8'h00, 8'h02, 8'h00, 8'h00};
      send_file();
      // Directed: no sections, one all-extremes point whose last byte is
      // also end of file, so one byte yields a point and an ok status.
      file_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h80, 8'h81,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h80, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF};
      send_file();

      // Random files until the byte budget is used.
      while (sb.bytes_taken < 925) begin
         calm = ($urandom_range(0, 4) == 0);
         file_bytes.delete();
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            // well-formed file, some of them cut short below
            file_bytes = '{8'h00, 8'h01, 8'h00, 8'h00};
            cnt = rand_count(3);
            push_varint(cnt, rand_groups(cnt));
            nsec = cnt[31] ? 31'd0 : cnt[30:0];
            for (int s = 0; s < nsec; s++) begin
               pairs = rand_count(3);
               push_varint(pairs, rand_groups(pairs));
               if (!pairs[31]) begin
                  for (int p = 0; p < 2 * pairs; p++) begin
                     // header values: arbitrary length, content is skipped
                     n = $urandom_range(0, 6);
                     repeat (n) file_bytes.push_back(8'($urandom_range(0, 127)));
                     file_bytes.push_back(8'($urandom_range(128, 255)));
                  end
               end
            end
            cnt = rand_count(6);
            push_varint(cnt, rand_groups(cnt));
            npts = cnt[31] ? 31'd0 : cnt[30:0];
            for (int k = 0; k < npts; k++) begin
               fill = $urandom_range(0, 9);
               repeat (14) begin
                  if (fill == 0)      file_bytes.push_back(8'hFF);
                  else if (fill == 1) file_bytes.push_back(8'h00);
                  else                file_bytes.push_back(8'($urandom));
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 5);
               repeat (n) file_bytes.push_back(8'($urandom));
            end
            if (kind >= 65 && file_bytes.size() > 1) begin
               n = $urandom_range(1, file_bytes.size() - 1);
               while (file_bytes.size() > n) void'(file_bytes.pop_back());
            end
         end else if (kind < 90) begin
            // bad version word followed by junk that must be ignored
            case ($urandom_range(0, 4))
               0:       word = VERSION_1_0 ^ (32'h1 << $urandom_range(0, 31));
               1:       word = 32'h0000_0000;
               2:       word = 32'hFFFF_FFFF;
               3:       word = 32'h0002_0000;
               default: word = $urandom;
            endcase
            for (int j = 3; j >= 0; j--) file_bytes.push_back(word[8*j +: 8]);
            n = $urandom_range(0, 20);
            repeat (n) file_bytes.push_back(8'($urandom));
         end else begin
            // plain noise
            n = $urandom_range(1, 25);
            repeat (n) file_bytes.push_back(8'($urandom));
         end
         send_file();
      end
      req_valid <= 1'b0;

      // Drain, then a few more cycles to catch stray items.
      drain = 0;
      while (sb.awaited_items.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (sb.awaited_items.size() != 0)
         sb.report($sformatf("%0d expected items never arrived", sb.awaited_items.size()));

      $display("Sent %0d bytes in %0d files; %0d point items checked.",
               sb.bytes_taken, sb.files_seen, sb.points_seen);
      $display("End-of-file status: %0d ok, %0d bad version, %0d truncated.",
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_BAD_VERSION],
               sb.status_seen[STATUS_TRUNCATED]);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
